// ===== hw/rtl/bpc_pkg.sv =====
// Shared types and constants for the button press classifier.
package bpc_pkg;

	localparam int TIME_BITS = 32;
	localparam int NOW_W     = 32;
	localparam int THR_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int FLAG_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 1'd1;

	localparam int FLAG_RELEASED = 0;
	localparam int FLAG_BUMPED   = 1;
	localparam int FLAG_SHORT    = 2;
	localparam int FLAG_LONG     = 3;

	localparam logic [THR_W-1:0] SHORT_PRESS_RST = 16'd500;
	localparam logic [THR_W-1:0] LONG_PRESS_RST  = 16'd2000;

	typedef logic [TIME_BITS-1:0] time_val_t;
	typedef logic [FLAG_W-1:0]    flags_t;

	typedef struct packed {
		logic [THR_W-1:0] short_ms;
		logic [THR_W-1:0] long_ms;
	} thr_cfg_t;

	typedef struct packed {
		logic      prev_sample;
		logic      deb_pressed;
		logic      short_rep;
		logic      long_rep;
		time_val_t start_ms;
		flags_t    flags;
	} btn_state_t;

	typedef struct packed {
		logic [NOW_W-1:0] now_ms;
		logic             pin_level;
		flags_t           clears;
	} sample_t;

	// Timestamp reduced (or widened) to the time arithmetic width.
	function automatic time_val_t to_time(input logic [NOW_W-1:0] now);
		logic [63:0] wide;
		wide = {{(64-NOW_W){1'b0}}, now};
		return wide[TIME_BITS-1:0];
	endfunction

	function automatic time_val_t thr_time(input logic [THR_W-1:0] thr);
		logic [63:0] wide;
		wide = {{(64-THR_W){1'b0}}, thr};
		return wide[TIME_BITS-1:0];
	endfunction

endpackage

// ===== hw/rtl/bpc_sample_if.sv =====
// Input sample channel.
interface bpc_sample_if import bpc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NOW_W-1:0] now_ms;
	logic             pin_level;
	logic             clear_released;
	logic             clear_bumped;
	logic             clear_short;
	logic             clear_long;

	modport source (output valid, now_ms, pin_level, clear_released, clear_bumped,
		clear_short, clear_long, input ready);
	modport sink (input valid, now_ms, pin_level, clear_released, clear_bumped,
		clear_short, clear_long, output ready);
endinterface

// ===== hw/rtl/bpc_result_if.sv =====
// Result channel.
interface bpc_result_if ();
	logic valid;
	logic ready;
	logic pressed;
	logic released_flag;
	logic bumped_flag;
	logic short_flag;
	logic long_flag;

	modport source (output valid, pressed, released_flag, bumped_flag, short_flag,
		long_flag, input ready);
	modport sink (input valid, pressed, released_flag, bumped_flag, short_flag,
		long_flag, output ready);
endinterface

// ===== hw/rtl/bpc_cfg_if.sv =====
// Configuration write channel.
interface bpc_cfg_if import bpc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [THR_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bpc_cfg_regs.sv =====
// Threshold configuration registers.
module bpc_cfg_regs import bpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bpc_cfg_if.sink   cfg,
	output thr_cfg_t  thr
);
	thr_cfg_t thr_q;

	assign cfg.ready = 1'b1;
	assign thr       = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.short_ms <= SHORT_PRESS_RST;
			thr_q.long_ms  <= LONG_PRESS_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SHORT_PRESS: thr_q.short_ms <= cfg.data;
				REG_LONG_PRESS:  thr_q.long_ms  <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule

// ===== hw/rtl/bpc_classify.sv =====
// Debounce and press classification for one sample.
module bpc_classify import bpc_pkg::*; (
	input  btn_state_t st,
	input  sample_t    smp,
	input  thr_cfg_t   thr,
	output btn_state_t nxt,
	output logic       pressed,
	output flags_t     flags_out
);
	time_val_t now_t;
	time_val_t start_eff;
	time_val_t elapsed;
	time_val_t short_t;
	time_val_t long_t;
	logic      agree;

	assign now_t     = to_time(smp.now_ms);
	assign short_t   = thr_time(thr.short_ms);
	assign long_t    = thr_time(thr.long_ms);
	assign agree     = (smp.pin_level == st.prev_sample);
	assign start_eff = (smp.pin_level && !st.deb_pressed) ? now_t : st.start_ms;
	assign elapsed   = now_t - start_eff;

	always_comb begin
		btn_state_t s;
		s = st;
		if (agree) begin
			if (smp.pin_level) begin
				s.start_ms = start_eff;
				if (!st.short_rep && (elapsed > short_t)) begin
					s.flags[FLAG_SHORT] = 1'b1;
					s.short_rep         = 1'b1;
				end
				if (!st.long_rep && (elapsed > long_t)) begin
					s.flags[FLAG_LONG] = 1'b1;
					s.long_rep         = 1'b1;
				end
				s.deb_pressed = 1'b1;
			end else begin
				if (st.deb_pressed) begin
					if (elapsed < short_t)
						s.flags[FLAG_BUMPED] = 1'b1;
					s.flags[FLAG_RELEASED] = 1'b1;
					s.short_rep            = 1'b0;
					s.long_rep             = 1'b0;
				end
				s.deb_pressed = 1'b0;
			end
		end
		s.prev_sample = smp.pin_level;
		pressed       = s.deb_pressed;
		flags_out     = s.flags;
		// clears take effect after this result
		s.flags       = s.flags & ~smp.clears;
		nxt           = s;
	end
endmodule

// ===== hw/rtl/button_press_classifier.sv =====
// Top level of the button press classifier.
// Path: a sample is held in the input register, classified, then stored in the result register.
// One sample per cycle unless a result waits; then only an empty sample register takes one item.
// Reset (arst_n low): debounced state released, timestamp zero, all flags clear,
// thresholds 500 ms and 2000 ms. No clearing pass; samples are taken right after reset.
module button_press_classifier import bpc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bpc_sample_if.sink    sample,
	bpc_result_if.source  result,
	bpc_cfg_if.sink       cfg
);
	thr_cfg_t   thr;
	btn_state_t st_q;
	btn_state_t st_nxt;
	sample_t    smp_s1;
	logic       valid_s1;
	logic       adv_s1;
	logic       pressed_c;
	flags_t     flags_c;
	logic       out_valid_q;
	logic       pressed_q;
	flags_t     flags_q;

	bpc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.thr    (thr)
	);

	bpc_classify u_cls (
		.st        (st_q),
		.smp       (smp_s1),
		.thr       (thr),
		.nxt       (st_nxt),
		.pressed   (pressed_c),
		.flags_out (flags_c)
	);

	assign adv_s1       = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			smp_s1.now_ms    <= sample.now_ms;
			smp_s1.pin_level <= sample.pin_level;
			smp_s1.clears    <= {sample.clear_long, sample.clear_short,
				sample.clear_bumped, sample.clear_released};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv_s1) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pressed_q <= pressed_c;
			flags_q   <= flags_c;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.pressed       = pressed_q;
	assign result.released_flag = flags_q[FLAG_RELEASED];
	assign result.bumped_flag   = flags_q[FLAG_BUMPED];
	assign result.short_flag    = flags_q[FLAG_SHORT];
	assign result.long_flag     = flags_q[FLAG_LONG];

	a_reported_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.deb_pressed |-> (!st_q.short_rep && !st_q.long_rep))
		else $error("press report marks set while released");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !result.ready) |=> valid_s1)
		else $error("sample stage lost an item under stall");

	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a sample");

	a_release_clears_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && st_q.deb_pressed && !st_nxt.deb_pressed) |-> st_nxt.flags[FLAG_RELEASED]
			|| smp_s1.clears[FLAG_RELEASED])
		else $error("release without release flag");
endmodule
